// ----- src/dcrt_pkg.sv -----
// shared types and constants for the datagram chunk reassembly tracker
package dcrt_pkg;

   localparam int LEN_W      = 12;
   localparam int MAGIC_W    = 32;
   localparam int FRAME_W    = 32;
   localparam int CIDX_W     = 16;
   localparam int CTOT_W     = 16;
   localparam int BYTES_W    = 18;
   localparam int HELD_W     = 8;
   localparam int LIMIT_W    = 20;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 32;

   localparam logic [LEN_W-1:0]   HEADER_BYTES = 12'd12;
   localparam logic [BYTES_W-1:0] BYTE_SUM_MAX = 18'h3FFFF;
   localparam logic [HELD_W-1:0]  HELD_MAX     = 8'hFF;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 20'h40000;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_MAGIC = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_LIMIT   = 1'b1;

   typedef enum logic [3:0] {
      STAT_SHORT       = 4'd0,
      STAT_BAD_MAGIC   = 4'd1,
      STAT_ZERO_TOTAL  = 4'd2,
      STAT_INDEX_RANGE = 4'd3,
      STAT_TOO_MANY    = 4'd4,
      STAT_DUPLICATE   = 4'd5,
      STAT_ACCEPTED    = 4'd6,
      STAT_COMPLETE    = 4'd7,
      STAT_OVERFLOW    = 4'd8
   } status_type;

   typedef struct packed {
      logic [CTOT_W-1:0]  chunk_total;
      logic [CIDX_W-1:0]  chunk_index;
      logic [FRAME_W-1:0] frame_number;
      logic [MAGIC_W-1:0] header_magic;
      logic [LEN_W-1:0]   datagram_length;
   } item_type;

   typedef struct packed {
      logic [HELD_W-1:0]  chunks_held;
      logic [BYTES_W-1:0] frame_bytes;
      logic               dropped_partial;
      status_type         status;
   } result_type;

   // bitmap update issued when a header is committed
   typedef struct packed {
      logic clear;
      logic mark;
   } bm_cmd_type;

endpackage

// ----- src/dcrt_ram.sv -----
// generic single-port-write, registered-read ram
module dcrt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dcrt_bitmap.sv -----
// received-chunk bitmap: ram holds the marks, per-entry valid bits let all marks clear at once
module dcrt_bitmap #(
   parameter int MAX_CHUNKS = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [dcrt_pkg::CIDX_W-1:0] rd_index,
   input  logic [dcrt_pkg::CIDX_W-1:0] cur_index,
   input  dcrt_pkg::bm_cmd_type    cmd,
   output logic                    seen
);
   import dcrt_pkg::*;

   localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

   logic [MAX_CHUNKS-1:0] valid_ff;
   logic [MAX_CHUNKS-1:0] valid_in;
   logic                  mark_bit;
   logic [AW-1:0]         cur_addr;

   assign cur_addr = cur_index[AW-1:0];

   dcrt_ram #(
      .WIDTH (1),
      .DEPTH (MAX_CHUNKS)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (cmd.mark),
      .wr_addr (cur_addr),
      .wr_data (1'b1),
      .rd_en   (rd_en),
      .rd_addr (rd_index[AW-1:0]),
      .rd_data (mark_bit)
   );

   // an entry not valid since the last clear reads as unseen
   assign seen = valid_ff[cur_addr] & mark_bit;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end
      if (cmd.mark) begin
         valid_in[cur_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- src/dcrt_frame.sv -----
// header checks, frame state and result formation
module dcrt_frame #(
   parameter int MAX_CHUNKS   = 128,
   parameter int MAX_DATAGRAM = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  dcrt_pkg::item_type            item,
   input  logic [dcrt_pkg::MAGIC_W-1:0]  expected_magic,
   input  logic [dcrt_pkg::LIMIT_W-1:0]  buffer_limit,
   input  logic                          seen_raw,
   output dcrt_pkg::bm_cmd_type          bm_cmd,
   output dcrt_pkg::result_type          result
);
   import dcrt_pkg::*;

   localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

   logic               active_ff, active_in;
   logic [FRAME_W-1:0] cur_frame_ff, cur_frame_in;
   logic [CNT_W-1:0]   expected_ff, expected_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;

   logic [LEN_W-1:0]   len_c;
   status_type         check;
   logic               ok;
   logic               new_frame;
   logic               seen;
   logic [CNT_W-1:0]   base_count, base_expected, count_n;
   logic [BYTES_W-1:0] base_bytes, bytes_n;
   logic [BYTES_W:0]   sum;
   logic [CNT_W-1:0]   out_count;
   logic [BYTES_W-1:0] out_bytes;
   logic [31:0]        count_wide;

   always_comb begin
      len_c = item.datagram_length;
      if (32'(item.datagram_length) > MAX_DATAGRAM) begin
         len_c = LEN_W'(MAX_DATAGRAM);
      end

      if (len_c < HEADER_BYTES) begin
         check = STAT_SHORT;
      end else if (item.header_magic != expected_magic) begin
         check = STAT_BAD_MAGIC;
      end else if (item.chunk_total == '0) begin
         check = STAT_ZERO_TOTAL;
      end else if (item.chunk_index >= item.chunk_total) begin
         check = STAT_INDEX_RANGE;
      end else if (32'(item.chunk_total) > MAX_CHUNKS) begin
         check = STAT_TOO_MANY;
      end else begin
         check = STAT_ACCEPTED;
      end
      ok = (check == STAT_ACCEPTED);

      // idle or a different frame number starts over
      new_frame     = !active_ff || (item.frame_number != cur_frame_ff);
      seen          = !new_frame && seen_raw;
      base_count    = new_frame ? '0 : count_ff;
      base_bytes    = new_frame ? '0 : bytes_ff;
      base_expected = new_frame ? item.chunk_total[CNT_W-1:0] : expected_ff;

      count_n = base_count + CNT_W'(1);
      sum     = {1'b0, base_bytes} + (BYTES_W + 1)'(len_c - HEADER_BYTES);
      bytes_n = sum[BYTES_W] ? BYTE_SUM_MAX : sum[BYTES_W-1:0];

      active_in    = active_ff;
      cur_frame_in = cur_frame_ff;
      expected_in  = expected_ff;
      count_in     = count_ff;
      bytes_in     = bytes_ff;
      bm_cmd       = '0;

      result.status          = check;
      result.dropped_partial = 1'b0;
      out_count              = count_ff;
      out_bytes              = bytes_ff;

      if (ok) begin
         result.dropped_partial = new_frame && active_ff;
         bm_cmd.clear           = new_frame && commit;
         active_in              = 1'b1;
         cur_frame_in           = item.frame_number;
         expected_in            = base_expected;
         count_in               = base_count;
         bytes_in               = base_bytes;
         out_count              = base_count;
         out_bytes              = base_bytes;
         if (seen) begin
            result.status = STAT_DUPLICATE;
         end else begin
            bm_cmd.mark = commit;
            out_count   = count_n;
            out_bytes   = bytes_n;
            count_in    = count_n;
            bytes_in    = bytes_n;
            if (count_n == base_expected) begin
               result.status = ({2'b00, bytes_n} > buffer_limit) ? STAT_OVERFLOW
                                                                 : STAT_COMPLETE;
               // frame closed, number kept
               active_in   = 1'b0;
               expected_in = '0;
               count_in    = '0;
               bytes_in    = '0;
            end else begin
               result.status = STAT_ACCEPTED;
            end
         end
      end

      count_wide         = 32'(out_count);
      result.chunks_held = (count_wide > 32'(HELD_MAX)) ? HELD_MAX : count_wide[HELD_W-1:0];
      result.frame_bytes = out_bytes;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cur_frame_ff <= '0;
         expected_ff  <= '0;
         count_ff     <= '0;
         bytes_ff     <= '0;
      end else if (commit) begin
         active_ff    <= active_in;
         cur_frame_ff <= cur_frame_in;
         expected_ff  <= expected_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
      end
   end

endmodule

// ----- src/datagram_chunk_reassembly_tracker.sv -----
// top level of the datagram chunk reassembly tracker
//
// req channel: one parsed datagram header per beat (length, magic, frame
//   number, chunk index, chunk total); rsp channel: one result beat per
//   request beat (status, dropped-partial flag, byte sum, chunks held)
// csr port: write-only, index 0 expected magic, index 1 buffer limit in bytes;
//   to be written only while no request is in flight; the block does not enforce this
// timing: a request beat is taken when the block is idle and issues the chunk
//   bitmap ram read at that edge; in the next cycle the registered read data
//   is there and the result is formed; once the output register is free or
//   draining, the bitmap and frame state are written back and the result
//   lands in the output register; a new request beat is taken only after that
// the bitmap ram read and write-back of one header never overlap with the
//   next header, which is read only after the write-back edge
// reset: frame state goes idle, bitmap valid bits clear, magic
//   reads zero and the buffer limit 262144
// rsp stall: the result waits in the output register while one more request
//   is taken and looked up; that header then holds until rsp_tready frees
//   the output register
module datagram_chunk_reassembly_tracker #(
   parameter int MAX_CHUNKS   = 128,
   parameter int MAX_DATAGRAM = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // csr write port
   input  logic                              csr_wr_en,
   input  logic [dcrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dcrt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // datagram_length, header_magic, frame_number, chunk_index, chunk_total, pad
   input  logic [dcrt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, dropped_partial, frame_bytes, chunks_held, pad
   output logic [dcrt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import dcrt_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_LOOK
   } state_type;

   state_type          state_ff;
   item_type           item_ff;
   item_type           req_item;
   logic               rsp_valid_ff;
   result_type         rsp_data_ff;
   logic [MAGIC_W-1:0] magic_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic               req_beat;
   logic               commit;
   logic               seen_raw;
   bm_cmd_type         bm_cmd;
   result_type         result;

   assign req_item   = req_tdata[$bits(item_type)-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   // finish the lookup once the output register is free or draining
   assign commit     = (state_ff == S_LOOK) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(result_type))'(0), rsp_data_ff};

   dcrt_bitmap #(
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_bitmap (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_beat),
      .rd_index  (req_item.chunk_index),
      .cur_index (item_ff.chunk_index),
      .cmd       (bm_cmd),
      .seen      (seen_raw)
   );

   dcrt_frame #(
      .MAX_CHUNKS   (MAX_CHUNKS),
      .MAX_DATAGRAM (MAX_DATAGRAM)
   ) u_frame (
      .clock          (clock),
      .reset          (reset),
      .commit         (commit),
      .item           (item_ff),
      .expected_magic (magic_ff),
      .buffer_limit   (limit_ff),
      .seen_raw       (seen_raw),
      .bm_cmd         (bm_cmd),
      .result         (result)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EXPECTED_MAGIC: magic_ff <= csr_wdata[MAGIC_W-1:0];
            CSR_BUFFER_LIMIT:   limit_ff <= csr_wdata[LIMIT_W-1:0];
            default:            ;
         endcase
      end
   end

   // control state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a commit refills the output register in the cycle it drains
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               if (commit) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff <= req_item;
      end
      if (commit) begin
         rsp_data_ff <= result;
      end
   end

endmodule
